// ----- sv/itf_pkg.sv -----
// Shared types, constants and helpers for the integer-to-text formatter.
`timescale 1ns / 1ps
package itf_pkg;

    localparam int MAX_CHARS_DEF = 32;
    localparam int NUM_DIGITS    = 10;
    localparam int CNT_W         = 7;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        t_digits          digits;
        logic [3:0]       nsig;
        logic             upper;
        logic             has_sign;
        logic             neg;
        logic [CNT_W-1:0] pre;
        logic [CNT_W-1:0] zeros;
        logic [CNT_W-1:0] post;
        logic [CNT_W-1:0] chars;
    } t_job;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [15:0][7:0] HEX_UPPER = {
        8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30};
    localparam logic [15:0][7:0] HEX_LOWER = {
        8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30};

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        return upper ? HEX_UPPER[d] : HEX_LOWER[d];
    endfunction

endpackage

// ----- sv/itf_front.sv -----
// Front end: accepts numbers, converts to digits and sizes the sign, padding and digit runs.
`timescale 1ns / 1ps
module itf_front import itf_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_magnitude,
    input  logic        i_is_negative,
    input  logic        i_hex_base,
    input  logic        i_upper_case,
    input  logic [5:0]  i_field_width,
    input  logic [6:0]  i_min_digits,
    input  logic        i_left_align,
    input  logic        i_zero_fill,
    input  logic        i_space_sign,
    output logic        o_q_push,
    output t_job        o_job,
    input  logic        i_q_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [5:0] SAT     = 6'(MAX_CHARS);

    logic [1:0]  r_st, n_st;
    logic [4:0]  r_cnt;
    logic [31:0] r_bin;
    t_digits     r_bcd;
    logic        r_neg, r_upper, r_left, r_zfill, r_space, r_pnone;
    logic [5:0]  r_width, r_prec;

    logic        accept;
    t_digits     adj;
    logic [3:0]  nsig;
    logic [CNT_W-1:0] prec_e, ndig, total, wid7, pad;

    assign full   = (r_st != ST_IDLE);
    assign accept = push && !full;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        nsig = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                nsig = 4'(i + 1);
            end
        end
    end

    always_comb begin
        prec_e = r_pnone ? CNT_W'(1) : CNT_W'(r_prec);
        ndig   = (CNT_W'(nsig) > prec_e) ? CNT_W'(nsig) : prec_e;
        total  = ndig + CNT_W'(r_neg | r_space);
        wid7   = CNT_W'(r_width);
        pad    = (wid7 > total) ? wid7 - total : '0;

        o_job.digits   = r_bcd;
        o_job.nsig     = nsig;
        o_job.upper    = r_upper;
        o_job.has_sign = r_neg | r_space;
        o_job.neg      = r_neg;
        o_job.pre      = (!r_left && !r_zfill) ? pad : '0;
        o_job.zeros    = ((!r_left && r_zfill) ? pad : '0) + (ndig - CNT_W'(nsig));
        o_job.post     = r_left ? pad : '0;
        o_job.chars    = total + pad;
    end

    assign o_q_push = (r_st == ST_DONE) && (o_job.chars != '0) && !i_q_full;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    n_st = i_hex_base ? ST_DONE : ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == 5'd31) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (o_job.chars == '0 || !i_q_full) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt   <= 5'd0;
            r_bin   <= i_magnitude;
            r_bcd   <= i_hex_base ? t_digits'({8'h00, i_magnitude}) : '0;
            r_neg   <= i_is_negative;
            r_upper <= i_upper_case;
            r_left  <= i_left_align;
            r_zfill <= i_zero_fill;
            r_space <= i_space_sign;
            r_width <= (i_field_width > SAT) ? SAT : i_field_width;
            r_pnone <= i_min_digits[6];
            r_prec  <= (i_min_digits[5:0] > SAT) ? SAT : i_min_digits[5:0];
        end else if (r_st == ST_CONV) begin
            r_cnt <= r_cnt + 5'd1;
            r_bcd <= t_digits'({adj[NUM_DIGITS-1:0], r_bin[31]});
            r_bin <= {r_bin[30:0], 1'b0};
        end
    end

    a_push_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (r_st == ST_DONE) && !i_q_full)
        else $error("job pushed outside done state or into full queue");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_st == ST_CONV) || (r_st == ST_DONE))
        else $error("accepted number did not start conversion");

endmodule

// ----- sv/itf_jobq.sv -----
// Two-entry queue of formatting jobs between the front end and the character emitter.
`timescale 1ns / 1ps
module itf_jobq import itf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_ent[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && ((r_cnt == 2'd1) == (r_wp != r_rp)))
        else $error("queue count and pointers disagree");

endmodule

// ----- sv/itf_back.sv -----
// Back end: walks a job and emits one character per cycle through an output register while pop keeps up.
`timescale 1ns / 1ps
module itf_back import itf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    logic [CNT_W-1:0] r_pre, r_zero, r_post, r_left;
    logic [3:0]       r_dig;
    logic             r_sign, r_neg, r_upper;
    t_digits          r_digits;
    logic             r_oval, r_last;
    logic [7:0]       r_char;

    logic       adv;
    logic [3:0] dig_idx;
    logic [7:0] n_char;

    assign adv     = (r_left != '0) && (!r_oval || pop);
    assign o_q_pop = (r_left == '0) && !i_q_empty;
    assign dig_idx = r_dig - 4'd1;

    always_comb begin
        priority if (r_pre != '0) begin
            n_char = CH_SPACE;
        end else if (r_sign) begin
            n_char = r_neg ? CH_MINUS : CH_SPACE;
        end else if (r_zero != '0) begin
            n_char = CH_ZERO;
        end else if (r_dig != 4'd0) begin
            n_char = digit_char(r_digits[dig_idx], r_upper);
        end else begin
            n_char = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pre  <= '0;
            r_zero <= '0;
            r_post <= '0;
            r_dig  <= 4'd0;
            r_sign <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_left <= i_job.chars;
                r_pre  <= i_job.pre;
                r_zero <= i_job.zeros;
                r_post <= i_job.post;
                r_dig  <= i_job.nsig;
                r_sign <= i_job.has_sign;
            end else if (adv) begin
                r_left <= r_left - CNT_W'(1);
                priority if (r_pre != '0) begin
                    r_pre <= r_pre - CNT_W'(1);
                end else if (r_sign) begin
                    r_sign <= 1'b0;
                end else if (r_zero != '0) begin
                    r_zero <= r_zero - CNT_W'(1);
                end else if (r_dig != 4'd0) begin
                    r_dig <= r_dig - 4'd1;
                end else begin
                    r_post <= r_post - CNT_W'(1);
                end
            end
            if (adv) begin
                r_oval <= 1'b1;
            end else if (pop) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_neg    <= i_job.neg;
            r_upper  <= i_job.upper;
            r_digits <= i_job.digits;
        end
        if (adv) begin
            r_char <= n_char;
            r_last <= (r_left == CNT_W'(1));
        end
    end

    assign empty       = !r_oval;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_left != '0)
        else $error("job with no characters reached the emitter");

    a_runs_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == '0) |-> (r_pre == '0) && (r_zero == '0) && (r_post == '0)
                           && (r_dig == 4'd0) && !r_sign)
        else $error("character runs left over after job ended");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_left == CNT_W'(1))) |=> (r_left == '0))
        else $error("last character emitted while job still running");

endmodule

// ----- sv/integer_to_text_formatter_core.sv -----
// Top level of the printf-style integer-to-text formatter.
// Usage:
//   Input queue side: drive the number and its format controls with push;
//   a transfer happens on a clock edge with push high and full low.
//   Output queue side: while empty is low, o_out_char/o_last_char show the
//   oldest character; a transfer happens on an edge with pop high and empty low.
//   Characters leave most significant first; o_last_char marks the final one.
//   A zero with precision 0 and no sign or padding yields no characters.
// Flow:
//   The front end takes one number at a time: decimal numbers go through
//   32 shift-add-3 binary-to-BCD steps, hex numbers skip the conversion.
//   A two-entry job queue decouples it from the emitter, which loads each
//   number from the queue and then sends one character per cycle while pop keeps up.
// Reset: synchronous active-low i_rst_n empties the queue and the output.
// Stall: with pop low the output holds; full is high while the front end
//   holds a number, and stays high while it waits for room in the job queue.
`timescale 1ns / 1ps
module integer_to_text_formatter_core import itf_pkg::*; #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_magnitude,
    input  logic        i_is_negative,
    input  logic        i_hex_base,
    input  logic        i_upper_case,
    input  logic [5:0]  i_field_width,
    input  logic signed [6:0] i_min_digits,
    input  logic        i_left_align,
    input  logic        i_zero_fill,
    input  logic        i_space_sign,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    logic q_push, q_full, q_pop, q_empty;
    t_job job_in, job_out;

    itf_front #(.MAX_CHARS(MAX_CHARS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_magnitude   (i_magnitude),
        .i_is_negative (i_is_negative),
        .i_hex_base    (i_hex_base),
        .i_upper_case  (i_upper_case),
        .i_field_width (i_field_width),
        .i_min_digits  (i_min_digits),
        .i_left_align  (i_left_align),
        .i_zero_fill   (i_zero_fill),
        .i_space_sign  (i_space_sign),
        .o_q_push      (q_push),
        .o_job         (job_in),
        .i_q_full      (q_full)
    );

    itf_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    itf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule
